// ----- hw/rtl/vwit_pkg.sv -----
// Shared types, constants and codes for the vertex weld index table.
`default_nettype none
package vwit_pkg;

	localparam int GROUPS_DEF      = 8;
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int INDEX_BITS_DEF  = 24;

	localparam int FIELD_W   = 24;
	localparam int GRP_W     = 3;
	localparam int KEY_W     = GRP_W + 3 * FIELD_W;
	localparam int CFG_W     = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WELD_MODE         = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORMALS_PRESENT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEXCOORDS_PRESENT = 2'd2;

	localparam logic [1:0] MODE_DUP  = 2'd0;
	localparam logic [1:0] MODE_POS  = 2'd1;
	localparam logic [1:0] MODE_FULL = 2'd2;
	// Unused mode code; it behaves as full-triple mode.
	localparam logic [1:0] MODE_RSVD = 2'd3;

	typedef struct packed {
		logic               restart;
		logic [GRP_W-1:0]   group_number;
		logic [FIELD_W-1:0] position_index;
		logic [FIELD_W-1:0] normal_idx;
		logic [FIELD_W-1:0] texcoord_idx;
	} in_t;

	typedef struct packed {
		logic [FIELD_W-1:0] vert_idx;
		logic               is_new_vertex;
		logic               table_overflow;
		logic               count_saturated;
	} out_t;

	// One classified corner waiting for the table engine.
	typedef struct packed {
		logic             restart;
		logic             lookup;
		logic [GRP_W-1:0] grp;
		logic [KEY_W-1:0] key;
	} job_t;

	// Status from the table engine back to the front end.
	typedef struct packed {
		logic pop;
		logic init;
	} ctl_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_READ,
		ST_CHECK,
		ST_ISSUE
	} state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/vertex_weld_index_table.sv -----
// Top level of the vertex weld index table: configuration registers and the two halves.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------
//  in       | in_valid / in_stall    | in_item  (restart, group, indices)
//  out      | out_valid / out_stall  | out_item (vertex index, flags)
//  cfg      | cfg_write              | cfg_index, cfg_data
//
// With an idle engine, a corner that skips the table passes through queue pop, start
// and issue before its result shows. A lookup adds a read, then a compare, for each
// probe of the single-port table memory. After reset, and for an item with restart
// set, the table is swept one entry per cycle; no item is taken in the reset sweep.
// A two-entry queue sits between the front end and the table engine, and a result
// register lets the engine work on the next item up to its result while a stalled
// result waits.
`default_nettype none
module vertex_weld_index_table #(
	parameter int GROUPS      = vwit_pkg::GROUPS_DEF,
	parameter int TABLE_DEPTH = vwit_pkg::TABLE_DEPTH_DEF,
	parameter int INDEX_BITS  = vwit_pkg::INDEX_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire vwit_pkg::in_t                      in_item,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output vwit_pkg::out_t                          out_item,
	input  wire logic                               cfg_write,
	input  wire logic [vwit_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [vwit_pkg::CFG_W-1:0]         cfg_data
);
	import vwit_pkg::*;

	logic [1:0] weld_mode_q;
	logic       normals_present_q;
	logic       texcoords_present_q;
	job_t       job;
	logic       job_valid;
	ctl_t       ctl;

	// Writes to an index past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weld_mode_q         <= MODE_FULL;
			normals_present_q   <= 1'b0;
			texcoords_present_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WELD_MODE:         weld_mode_q         <= cfg_data;
				REG_NORMALS_PRESENT:   normals_present_q   <= cfg_data[0];
				REG_TEXCOORDS_PRESENT: texcoords_present_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	vwit_front #(
		.GROUPS(GROUPS)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.in_item           (in_item),
		.weld_mode         (weld_mode_q),
		.normals_present   (normals_present_q),
		.texcoords_present (texcoords_present_q),
		.ctl               (ctl),
		.job               (job),
		.job_valid         (job_valid)
	);

	vwit_back #(
		.GROUPS      (GROUPS),
		.TABLE_DEPTH (TABLE_DEPTH),
		.INDEX_BITS  (INDEX_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.job_valid (job_valid),
		.ctl       (ctl),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/vwit_front.sv -----
// Front end: classifies each corner into a key and holds it in a two-entry queue.
`default_nettype none
module vwit_front #(
	parameter int GROUPS = vwit_pkg::GROUPS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire vwit_pkg::in_t in_item,
	input  wire logic [1:0]    weld_mode,
	input  wire logic          normals_present,
	input  wire logic          texcoords_present,
	input  wire vwit_pkg::ctl_t ctl,
	output vwit_pkg::job_t     job,
	output logic               job_valid
);
	import vwit_pkg::*;

	logic [GRP_W-1:0]   grp;
	logic [FIELD_W-1:0] kn;
	logic [FIELD_W-1:0] kt;
	logic               full_key;
	job_t               job_new;
	logic               push;

	job_t       fifo_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	// Group numbers are folded into the configured group count.
	always_comb begin
		grp = '0;
		for (int i = 0; i < 8; i++) begin
			if (in_item.group_number == GRP_W'(i)) begin
				grp = GRP_W'(i % GROUPS);
			end
		end
	end

	assign full_key = (weld_mode != MODE_POS);
	assign kn = (full_key && normals_present) ? in_item.normal_idx : '1;
	assign kt = (full_key && texcoords_present) ? in_item.texcoord_idx : '1;

	always_comb begin
		job_new.restart = in_item.restart;
		job_new.lookup  = (weld_mode != MODE_DUP);
		job_new.grp     = grp;
		job_new.key     = {grp, in_item.position_index, kn, kt};
	end

	assign in_stall  = ctl.init || (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign job       = fifo_q[rp_q];
	assign job_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= job_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (ctl.pop) begin
				rp_q <= !rp_q;
			end
			unique case ({push, ctl.pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/vwit_back.sv -----
// Table engine: hashed linear-probe lookup, insertion, group counters and result register.
`default_nettype none
module vwit_back #(
	parameter int GROUPS      = vwit_pkg::GROUPS_DEF,
	parameter int TABLE_DEPTH = vwit_pkg::TABLE_DEPTH_DEF,
	parameter int INDEX_BITS  = vwit_pkg::INDEX_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire vwit_pkg::job_t job,
	input  wire logic           job_valid,
	output vwit_pkg::ctl_t      ctl,
	output logic                out_valid,
	input  wire logic           out_stall,
	output vwit_pkg::out_t      out_item
);
	import vwit_pkg::*;

	localparam int AB  = $clog2(TABLE_DEPTH);
	localparam int GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int EW  = 1 + KEY_W + INDEX_BITS;
	localparam int NCH = (KEY_W + AB - 1) / AB;
	localparam logic [AB-1:0] LAST = AB'(TABLE_DEPTH - 1);
	localparam logic [INDEX_BITS-1:0] CMAX = {INDEX_BITS{1'b1}};

	state_t state_q, state_d;
	logic [AB-1:0] addr_q, addr_d, probes_q, probes_d, addr_next;
	logic slot_ok_q, slot_d, pend_q, pend_d;
	job_t job_q;
	logic [INDEX_BITS-1:0] cnt_q [GROUPS];
	logic out_valid_q;
	out_t out_q, out_d;

	logic [EW-1:0] mem [TABLE_DEPTH];
	logic [EW-1:0] rd_q;

	logic [NCH*AB-1:0] kx;
	logic [AB-1:0] fold, hash;
	logic [5:0] gx;
	logic [GW-1:0] gidx;
	logic [INDEX_BITS-1:0] cnt;
	logic sat, rd_valid, match, out_free;
	logic pop, we, emit, cnt_clr, cnt_bump;
	logic [EW-1:0] wdata;

	// Home slot: XOR fold of the key, brought below the depth.
	always_comb begin
		kx   = (NCH*AB)'(job_q.key);
		fold = '0;
		for (int i = 0; i < NCH; i++) begin
			fold = fold ^ kx[i*AB +: AB];
		end
		hash = ({1'b0, fold} >= (AB+1)'(TABLE_DEPTH)) ? fold - AB'(TABLE_DEPTH) : fold;
	end

	assign addr_next = (addr_q == LAST) ? '0 : addr_q + 1'b1;
	assign gx        = 6'(job_q.grp);
	assign gidx      = gx[GW-1:0];
	assign cnt       = cnt_q[gidx];
	assign sat       = (cnt == CMAX);
	assign rd_valid  = rd_q[EW-1];
	assign match     = rd_valid && (rd_q[EW-2 -: KEY_W] == job_q.key);
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		addr_d   = addr_q;
		probes_d = probes_q;
		slot_d   = slot_ok_q;
		pend_d   = pend_q;
		pop      = 1'b0;
		we       = 1'b0;
		wdata    = '0;
		emit     = 1'b0;
		out_d    = '0;
		cnt_clr  = 1'b0;
		cnt_bump = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				we     = 1'b1;
				addr_d = addr_next;
				if (addr_q == LAST) begin
					state_d = pend_q ? ST_START : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (job_valid) begin
					pop    = 1'b1;
					pend_d = 1'b1;
					if (job.restart) begin
						cnt_clr = 1'b1;
						addr_d  = '0;
						state_d = ST_CLEAR;
					end else begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				if (job_q.lookup) begin
					addr_d   = hash;
					probes_d = '0;
					state_d  = ST_READ;
				end else begin
					slot_d  = 1'b0;
					state_d = ST_ISSUE;
				end
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				priority if (match) begin
					if (out_free) begin
						emit           = 1'b1;
						out_d.vert_idx = FIELD_W'(rd_q[INDEX_BITS-1:0]);
						pend_d         = 1'b0;
						state_d        = ST_IDLE;
					end
				end else if (!rd_valid) begin
					slot_d  = 1'b1;
					state_d = ST_ISSUE;
				end else if (probes_q == LAST) begin
					slot_d  = 1'b0;
					state_d = ST_ISSUE;
				end else begin
					addr_d   = addr_next;
					probes_d = probes_q + 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_ISSUE: begin
				if (out_free) begin
					emit                  = 1'b1;
					pend_d                = 1'b0;
					state_d               = ST_IDLE;
					cnt_bump              = !sat;
					out_d.vert_idx        = FIELD_W'(cnt);
					out_d.is_new_vertex   = 1'b1;
					out_d.count_saturated = sat;
					out_d.table_overflow  = job_q.lookup && !sat && !slot_ok_q;
					if (job_q.lookup && !sat && slot_ok_q) begin
						we    = 1'b1;
						wdata = {1'b1, job_q.key, cnt};
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			probes_q    <= '0;
			slot_ok_q   <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			addr_q    <= addr_d;
			probes_q  <= probes_d;
			slot_ok_q <= slot_d;
			pend_q    <= pend_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < GROUPS; g++) begin
				cnt_q[g] <= '0;
			end
		end else if (cnt_clr) begin
			for (int g = 0; g < GROUPS; g++) begin
				cnt_q[g] <= '0;
			end
		end else if (cnt_bump) begin
			cnt_q[gidx] <= cnt + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
		if (emit) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr_q] <= wdata;
		end
		if (state_q == ST_READ) begin
			rd_q <= mem[addr_q];
		end
	end

	assign ctl.pop   = pop;
	assign ctl.init  = (state_q == ST_CLEAR) && !pend_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
`default_nettype wire

// ----- hw/rtl/vwit_checker.sv -----
// Port-level checks for the vertex weld index table, bound to the top level.
`default_nettype none
module vwit_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_stall,
	input wire logic           out_valid,
	input wire logic           out_stall,
	input wire vwit_pkg::out_t out_item
);

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// A hit carries no error flags.
	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.is_new_vertex |->
		!out_item.table_overflow && !out_item.count_saturated)
		else $error("flags set on a hit");

	// A saturated counter never also reports overflow.
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.count_saturated |-> !out_item.table_overflow)
		else $error("overflow and saturation together");

	// Right after a reset edge the input is held off and no result is shown.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> in_stall && !out_valid)
		else $error("block active right after reset");

endmodule

bind vertex_weld_index_table vwit_checker u_vwit_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
`default_nettype wire

// ----- tb/vertex_weld_index_table_tb.sv -----
// Self-checking testbench for the vertex weld index table.
`default_nettype none
module vertex_weld_index_table_tb;
	import vwit_pkg::*;

	localparam int CYCLE_LIMIT = 10000000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [23:0] ALL_ONES = 24'hFFFFFF;
	localparam logic [23:0] COUNT_TOP = 24'hFFFFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_item;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	vertex_weld_index_table uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Items waiting to be offered, and the results the predictor expects, oldest first.
	in_t corner_queue[$];
	out_t expected_vertices[$];

	// Predictor state: the set of stored keys with their indices, per-group counters
	// and the shadow copy of the configuration registers.
	logic [23:0] weld_map[logic [74:0]];
	int unsigned keys_stored;
	logic [23:0] next_vertex[8];
	logic [1:0] mode_reg;
	logic normals_reg;
	logic texcoords_reg;

	int send_idle_pct = 18;
	int recv_idle_pct = 54;
	logic long_hold_go = 1'b0;
	logic long_hold_done = 1'b0;
	int hold_count = 0;
	logic in_fire = 1'b0;

	int mismatches = 0;
	int results_seen = 0;
	int corners_sent = 0;
	int hits_seen = 0;
	int overflows_seen = 0;
	int cycle_count = 0;

	// Clears every stored key and group counter, as a restart or reset does.
	task automatic clear_welds();
		weld_map.delete();
		keys_stored = 0;
		foreach (next_vertex[g]) next_vertex[g] = '0;
	endtask

	// Works out the vertex index and flags for one accepted corner.
	task automatic predict_vertex(input in_t c);
		logic [74:0] key;
		logic [23:0] kn;
		logic [23:0] kt;
		logic full_key;
		logic record;
		out_t r;
		r = '0;
		record = 1'b0;
		if (c.restart) clear_welds();
		if (mode_reg != MODE_DUP) begin
			full_key = (mode_reg != MODE_POS);
			kn = (full_key && normals_reg) ? c.normal_idx : ALL_ONES;
			kt = (full_key && texcoords_reg) ? c.texcoord_idx : ALL_ONES;
			key = {c.group_number, c.position_index, kn, kt};
			if (weld_map.exists(key)) begin
				r.vert_idx = weld_map[key];
				expected_vertices.insert(expected_vertices.size(), r);
				return;
			end
			record = 1'b1;
		end
		r.is_new_vertex = 1'b1;
		if (next_vertex[c.group_number] == COUNT_TOP) begin
			r.vert_idx = COUNT_TOP;
			r.count_saturated = 1'b1;
			record = 1'b0;
		end else begin
			r.vert_idx = next_vertex[c.group_number];
			next_vertex[c.group_number] = next_vertex[c.group_number] + 24'd1;
		end
		if (record) begin
			if (keys_stored < TABLE_DEPTH_DEF) begin
				weld_map[key] = r.vert_idx;
				keys_stored++;
			end else begin
				r.table_overflow = 1'b1;
			end
		end
		expected_vertices.insert(expected_vertices.size(), r);
	endtask

	// Both handshakes are observed at the rising edge, where the block samples them.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
		if (arst_n) begin
			in_fire <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				predict_vertex(in_item);
				corners_sent++;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_vertices.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result: %p", out_item);
				end else begin
					if (out_item !== expected_vertices[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Result mismatch: expected %p, got %p",
								expected_vertices[0], out_item);
					end
					if (!expected_vertices[0].is_new_vertex) hits_seen++;
					if (expected_vertices[0].table_overflow) overflows_seen++;
					void'(expected_vertices.pop_front());
				end
			end
		end
	end

	// The driver offers the oldest pending item, idling at random between items.
	// A stalled item is held unchanged until it is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (in_fire) void'(corner_queue.pop_front());
			if (corner_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_item <= corner_queue[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// The receiver stalls at random, and once holds off for a long stretch so
	// that the block backs up and stalls its own input.
	always @(negedge clk) begin
		if (long_hold_go && !long_hold_done) begin
			out_stall <= 1'b1;
			hold_count++;
			if (hold_count >= HOLD_CYCLES) long_hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_WELD_MODE: mode_reg = val;
			REG_NORMALS_PRESENT: normals_reg = val[0];
			REG_TEXCOORDS_PRESENT: texcoords_reg = val[0];
			default: ;
		endcase
	endtask

	task automatic set_mode(input logic [1:0] m, input logic n, input logic t);
		write_reg(REG_WELD_MODE, m);
		write_reg(REG_NORMALS_PRESENT, {1'b0, n});
		write_reg(REG_TEXCOORDS_PRESENT, {1'b0, t});
	endtask

	// Waits until every item is taken and answered, then lets the engine drain.
	task automatic drain();
		while (corner_queue.size() != 0 || in_valid || expected_vertices.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic add_corner(input logic rs, input logic [2:0] g, input logic [23:0] p,
			input logic [23:0] n, input logic [23:0] t);
		in_t c;
		c.restart = rs;
		c.group_number = g;
		c.position_index = p;
		c.normal_idx = n;
		c.texcoord_idx = t;
		corner_queue.insert(corner_queue.size(), c);
	endtask

	// Mostly indices from a small pool so that keys repeat, sometimes the extremes
	// and sometimes fully random values.
	function automatic logic [23:0] pick_index();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 24'($urandom_range(11));
		if (r < 70) return ALL_ONES;
		if (r < 75) return '0;
		return 24'($urandom);
	endfunction

	task automatic random_corners(input int count);
		repeat (count)
			add_corner($urandom_range(79) == 0, 3'($urandom), pick_index(),
				pick_index(), pick_index());
	endtask

	initial begin
		mode_reg = MODE_FULL;
		normals_reg = 1'b0;
		texcoords_reg = 1'b0;
		clear_welds();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed corners under the reset setting: full mode with only the position
		// in the key, so the normal and texcoord do not matter.
		add_corner(1'b0, 3'd0, 24'd0, 24'd5, 24'd6);
		add_corner(1'b0, 3'd0, 24'd0, 24'd9, 24'd1);
		add_corner(1'b0, 3'd7, ALL_ONES, ALL_ONES, ALL_ONES);
		add_corner(1'b0, 3'd7, ALL_ONES, 24'd0, 24'd0);
		add_corner(1'b0, 3'd3, 24'd0, 24'd0, 24'd0);
		drain();

		// Normal and texcoord enter the key without a restart: an old key, with its
		// absent attributes all ones, still matches a real index of all ones.
		set_mode(MODE_FULL, 1'b1, 1'b1);
		add_corner(1'b0, 3'd0, 24'd0, ALL_ONES, ALL_ONES);
		add_corner(1'b0, 3'd0, 24'd0, 24'd1, ALL_ONES);
		add_corner(1'b0, 3'd0, 24'd0, 24'd1, ALL_ONES);
		add_corner(1'b0, 3'd0, 24'd0, 24'd1, 24'd2);
		add_corner(1'b1, 3'd0, 24'd0, ALL_ONES, ALL_ONES);
		add_corner(1'b0, 3'd0, 24'd0, ALL_ONES, ALL_ONES);
		drain();

		// Duplicate mode never looks up, then the unused mode acts as full mode.
		set_mode(MODE_DUP, 1'b1, 1'b0);
		add_corner(1'b0, 3'd0, 24'd0, ALL_ONES, ALL_ONES);
		add_corner(1'b0, 3'd0, 24'd0, ALL_ONES, ALL_ONES);
		add_corner(1'b0, 3'd5, 24'h800000, 24'd3, 24'd3);
		drain();
		write_reg(REG_WELD_MODE, MODE_RSVD);
		add_corner(1'b0, 3'd5, 24'h800000, 24'd3, 24'd3);
		add_corner(1'b0, 3'd5, 24'h800000, 24'd3, 24'd4);
		add_corner(1'b0, 3'd5, 24'h800000, 24'd4, 24'd4);
		add_corner(1'b0, 3'd5, 24'h800000, 24'd3, 24'd9);
		drain();

		// Random corners: sender idles less than the receiver, with one long hold-off.
		set_mode(MODE_FULL, 1'b1, 1'b1);
		random_corners(200);
		long_hold_go = 1'b1;
		drain();
		set_mode(MODE_POS, 1'b0, 1'b1);
		random_corners(150);
		drain();

		// Now the receiver idles less than the sender.
		send_idle_pct = 54;
		recv_idle_pct = 18;
		set_mode(MODE_DUP, 1'b0, 1'b0);
		random_corners(120);
		drain();
		set_mode(MODE_RSVD, 1'b1, 1'b0);
		random_corners(170);
		drain();

		// Neither side idles.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_mode(MODE_FULL, 1'b0, 1'b1);
		random_corners(230);
		drain();

		// A restart followed by the same key welds onto the fresh index.
		add_corner(1'b1, 3'd2, 24'd17, 24'd0, 24'd0);
		add_corner(1'b0, 3'd2, 24'd17, 24'd0, 24'd0);
		drain();

		$display("Run covered %0d corners and %0d results: %0d welded hits, %0d overflows.",
			corners_sent, results_seen, hits_seen, overflows_seen);
		$display("All weld modes, key attribute settings, restarts and a long output stall were used.");
		if (mismatches == 0 && expected_vertices.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
`default_nettype wire
